// File: src/assert_macros.svh
// assertion macros shared by the timer pool rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that holds at every clock edge out of reset
`define PTP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// same-cycle implication
`define PTP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTP_ASSERT(label, expr, msg)
`define PTP_ASSERT_IMP(label, ante, cons, msg)
`define PTP_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: src/ptp_pkg.sv
// shared widths, operation codes and status codes of the timer pool
package ptp_pkg;

  localparam int OP_W        = 2;
  localparam int PERIOD_W    = 32;
  localparam int SLOT_ID_W   = 4;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_USED = 2'd2
  } status_t;

endpackage

// File: src/ptp_in_if.sv
// command channel of the timer pool
interface ptp_in_if;
  import ptp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [PERIOD_W-1:0]  period;
  logic [SLOT_ID_W-1:0] slot_id;

  modport source (output valid, op, period, slot_id, input ready);
  modport sink   (input valid, op, period, slot_id, output ready);
endinterface

// File: src/ptp_out_if.sv
// result channel of the timer pool
interface ptp_out_if;
  import ptp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_ID_W-1:0] timer_slot;
  logic                 expired;
  logic                 last;

  modport source (output valid, status, timer_slot, expired, last, input ready);
  modport sink   (input valid, status, timer_slot, expired, last, output ready);
endinterface

// File: src/ptp_store.sv
// timer memory (period and count) and link memory of the timer pool
module ptp_store #(
  parameter int  NUM_TIMERS  = 16,
  parameter int  COUNT_WIDTH = 32,
  localparam int SlotW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                     clk,
  input  logic [SlotW-1:0]         rd_addr,
  input  logic                     tmr_we,
  input  logic [SlotW-1:0]         tmr_waddr,
  input  logic [2*COUNT_WIDTH-1:0] tmr_wdata,
  input  logic                     lnk_we,
  input  logic [SlotW-1:0]         lnk_waddr,
  input  logic [SlotW-1:0]         lnk_wdata,
  output logic [2*COUNT_WIDTH-1:0] tmr_rdata,
  output logic [SlotW-1:0]         lnk_rdata
);

  // entry layout: period in the upper half, count in the lower half
  logic [2*COUNT_WIDTH-1:0] tmr_mem [NUM_TIMERS];
  logic [SlotW-1:0]         lnk_mem [NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (tmr_we) begin
      tmr_mem[tmr_waddr] <= tmr_wdata;
    end
    tmr_rdata <= tmr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    lnk_rdata <= lnk_mem[rd_addr];
  end

endmodule

// File: src/periodic_timer_pool_unit.sv
// periodic timer pool: top level with command sequencer, active list and result register
//
// A pool of NUM_TIMERS periodic timers sharing one tick. Start claims the lowest free
// slot, loads its period, zeroes its count and links it at the tail of the active list;
// stop unlinks a slot and frees it; tick walks the list from head to tail, bumps each
// count and reports every count that reaches its period (the count then restarts at
// zero, period zero never fires). Periods and counts live in a timer memory and the
// forward links in a link memory, both with a registered read; the active flags, list
// head, tail and empty flag sit in flops, so there is no clearing pass after reset. One
// command is worked on at a time. Start and the unused op code are answered from their
// own state; stop is answered from its check state when the slot is the list head or
// not active, else it walks to the slot's predecessor and then unlinks the slot; tick
// reads, updates and writes back the timer memory one entry per cycle, held only when
// a second reported expiry meets a full result register whose sink holds ready low,
// which also holds back the final item of every command. The input is ready whenever
// no command is in progress, even while a result still waits in the output register.
// Up to sixteen expiries are reported per tick in list order, the last item of every
// command carries last, and a tick with no reported expiry gives one empty item.
`include "assert_macros.svh"

module periodic_timer_pool_unit #(
  parameter int  NUM_TIMERS  = 16,
  parameter int  COUNT_WIDTH = 32,
  localparam int SlotW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input logic    clk,
  input logic    rst_n,
  ptp_in_if.sink    in_chan,
  ptp_out_if.source out_chan
);
  import ptp_pkg::*;

  localparam int RcW = $clog2(MAX_RESULTS + 1);

  typedef enum logic [7:0] {
    S_IDLE        = 8'b0000_0001,
    S_START       = 8'b0000_0010,
    S_MISC        = 8'b0000_0100,
    S_STOP_CHK    = 8'b0000_1000,
    S_STOP_WALK   = 8'b0001_0000,
    S_STOP_UNLINK = 8'b0010_0000,
    S_TICK_WALK   = 8'b0100_0000,
    S_TICK_END    = 8'b1000_0000
  } state_t;

  // sequencer and list state
  state_t                  state_r, state_nxt;
  logic [NUM_TIMERS-1:0]   in_use_r, in_use_nxt;
  logic [SlotW-1:0]        head_r, head_nxt;
  logic [SlotW-1:0]        tail_r, tail_nxt;
  logic                    empty_r, empty_nxt;

  // walk pointer: current timer on tick, predecessor on stop
  logic [SlotW-1:0]        walk_r, walk_nxt;

  // expiry held back until we know whether it is the final item
  logic                    pend_valid_r, pend_valid_nxt;
  logic [SlotW-1:0]        pend_slot_r, pend_slot_nxt;
  logic [RcW-1:0]          rep_cnt_r, rep_cnt_nxt;

  // captured command operands
  logic [COUNT_WIDTH-1:0]  item_period_r;
  logic [SlotW-1:0]        item_slot_r;
  logic                    item_slot_ok_r;

  // result register
  logic                    out_valid_r;
  status_t                 out_status_r, out_status_nxt;
  logic [SLOT_ID_W-1:0]    out_slot_r, out_slot_nxt;
  logic                    out_expired_r, out_expired_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_load;
  logic                    out_free;

  // memory ports
  logic [SlotW-1:0]         rd_addr;
  logic                     tmr_we;
  logic [SlotW-1:0]         tmr_waddr;
  logic [2*COUNT_WIDTH-1:0] tmr_wdata;
  logic                     lnk_we;
  logic [SlotW-1:0]         lnk_waddr;
  logic [SlotW-1:0]         lnk_wdata;
  logic [2*COUNT_WIDTH-1:0] tmr_rdata;
  logic [SlotW-1:0]         lnk_rdata;

  // tick datapath
  logic [COUNT_WIDTH-1:0]  rd_period;
  logic [COUNT_WIDTH-1:0]  rd_count;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic                    hit;
  logic                    report;
  logic                    tick_stall;

  // lowest free slot
  logic                    free_found;
  logic [SlotW-1:0]        free_slot;

  logic                    in_acc;
  logic                    slot_live;

  ptp_store #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .tmr_we    (tmr_we),
    .tmr_waddr (tmr_waddr),
    .tmr_wdata (tmr_wdata),
    .lnk_we    (lnk_we),
    .lnk_waddr (lnk_waddr),
    .lnk_wdata (lnk_wdata),
    .tmr_rdata (tmr_rdata),
    .lnk_rdata (lnk_rdata)
  );

  assign in_chan.ready       = (state_r == S_IDLE);
  assign in_acc              = in_chan.valid && in_chan.ready;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.timer_slot = out_slot_r;
  assign out_chan.expired    = out_expired_r;
  assign out_chan.last       = out_last_r;

  // result register can take a new item this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  // read-modify-write of one timer entry
  assign rd_period  = tmr_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign rd_count   = tmr_rdata[COUNT_WIDTH-1:0];
  assign cnt_inc    = rd_count + COUNT_WIDTH'(1);
  assign hit        = (rd_period != '0) && (cnt_inc == rd_period);
  assign report     = hit && (rep_cnt_r < RcW'(MAX_RESULTS));
  // a second reported expiry has to push the held one out first
  assign tick_stall = report && pend_valid_r && !out_free;

  // slot named by stop is in range and active, which means it is on the list
  assign slot_live  = item_slot_ok_r && in_use_r[item_slot_r];

  // priority pick of the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_use_nxt      = in_use_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    empty_nxt       = empty_r;
    walk_nxt        = walk_r;
    pend_valid_nxt  = pend_valid_r;
    pend_slot_nxt   = pend_slot_r;
    rep_cnt_nxt     = rep_cnt_r;

    out_load        = 1'b0;
    out_status_nxt  = STAT_OK;
    out_slot_nxt    = '0;
    out_expired_nxt = 1'b0;
    out_last_nxt    = 1'b1;

    // idle keeps the head entry in the read registers for a following tick or stop
    rd_addr         = head_r;
    tmr_we          = 1'b0;
    tmr_waddr       = walk_r;
    tmr_wdata       = {rd_period, (hit ? {COUNT_WIDTH{1'b0}} : cnt_inc)};
    lnk_we          = 1'b0;
    lnk_waddr       = tail_r;
    lnk_wdata       = free_slot;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          walk_nxt       = head_r;
          pend_valid_nxt = 1'b0;
          rep_cnt_nxt    = '0;
          case (op_t'(in_chan.op))
            OP_TICK:  state_nxt = empty_r ? S_TICK_END : S_TICK_WALK;
            OP_START: state_nxt = S_START;
            OP_STOP:  state_nxt = S_STOP_CHK;
            default:  state_nxt = S_MISC;
          endcase
        end
      end

      S_START: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          if (free_found) begin
            in_use_nxt[free_slot] = 1'b1;
            tmr_we                = 1'b1;
            tmr_waddr             = free_slot;
            tmr_wdata             = {item_period_r, {COUNT_WIDTH{1'b0}}};
            tail_nxt              = free_slot;
            out_slot_nxt          = SLOT_ID_W'(free_slot);
            if (empty_r) begin
              head_nxt  = free_slot;
              empty_nxt = 1'b0;
            end else begin
              // append behind the old tail
              lnk_we    = 1'b1;
              lnk_waddr = tail_r;
              lnk_wdata = free_slot;
            end
          end else begin
            out_status_nxt = STAT_FULL;
          end
        end
      end

      S_MISC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_STOP_CHK: begin
        if (!slot_live) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_NOT_USED;
            state_nxt      = S_IDLE;
          end
        end else if (head_r == item_slot_r) begin
          // read registers already hold the head's link
          if (out_free) begin
            out_load                = 1'b1;
            in_use_nxt[item_slot_r] = 1'b0;
            state_nxt               = S_IDLE;
            if (head_r == tail_r) begin
              empty_nxt = 1'b1;
            end else begin
              head_nxt = lnk_rdata;
            end
          end
        end else begin
          state_nxt = S_STOP_WALK;
        end
      end

      S_STOP_WALK: begin
        // lnk_rdata is the successor of walk_r
        if (lnk_rdata == item_slot_r) begin
          rd_addr   = item_slot_r;
          state_nxt = S_STOP_UNLINK;
        end else begin
          walk_nxt = lnk_rdata;
          rd_addr  = lnk_rdata;
        end
      end

      S_STOP_UNLINK: begin
        rd_addr = item_slot_r;
        if (out_free) begin
          // predecessor now points past the stopped slot
          lnk_we                  = 1'b1;
          lnk_waddr               = walk_r;
          lnk_wdata               = lnk_rdata;
          in_use_nxt[item_slot_r] = 1'b0;
          out_load                = 1'b1;
          state_nxt               = S_IDLE;
          if (item_slot_r == tail_r) begin
            tail_nxt = walk_r;
          end
        end
      end

      S_TICK_WALK: begin
        rd_addr = walk_r;
        if (!tick_stall) begin
          tmr_we = 1'b1;
          if (report) begin
            if (pend_valid_r) begin
              out_load        = 1'b1;
              out_slot_nxt    = SLOT_ID_W'(pend_slot_r);
              out_expired_nxt = 1'b1;
              out_last_nxt    = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = walk_r;
            rep_cnt_nxt    = rep_cnt_r + RcW'(1);
          end
          if (walk_r == tail_r) begin
            state_nxt = S_TICK_END;
          end else begin
            walk_nxt = lnk_rdata;
            rd_addr  = lnk_rdata;
          end
        end
      end

      S_TICK_END: begin
        if (out_free) begin
          out_load       = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
          if (pend_valid_r) begin
            out_slot_nxt    = SLOT_ID_W'(pend_slot_r);
            out_expired_nxt = 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      empty_r      <= 1'b1;
      pend_valid_r <= 1'b0;
      rep_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      empty_r      <= empty_nxt;
      pend_valid_r <= pend_valid_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    walk_r      <= walk_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (in_acc) begin
      item_period_r  <= COUNT_WIDTH'(in_chan.period);
      item_slot_r    <= SlotW'(in_chan.slot_id);
      item_slot_ok_r <= (32'(in_chan.slot_id) < 32'(NUM_TIMERS));
    end
    if (out_load) begin
      out_status_r  <= out_status_nxt;
      out_slot_r    <= out_slot_nxt;
      out_expired_r <= out_expired_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  // list bookkeeping agrees with the active flags
  `PTP_ASSERT(a_empty_matches_use, empty_r == (in_use_r == '0), "empty flag out of step")
  `PTP_ASSERT_IMP(a_ends_active, !empty_r, in_use_r[head_r] && in_use_r[tail_r], "list end not active")
  // a held expiry never survives into idle
  `PTP_ASSERT_IMP(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r, "expiry left pending")
  // result register is never overwritten while its item waits
  `PTP_ASSERT_IMP(a_no_overwrite, out_load, out_free, "result item overwritten")
  // a walk never reports past the per-tick limit
  `PTP_ASSERT_NXT(a_rep_limit, state_r == S_TICK_WALK, rep_cnt_r <= RcW'(MAX_RESULTS), "too many expiries")

endmodule
